// File: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; every property is clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// holds whenever the design is out of reset
`define CMR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CMR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cmr_pkg.sv
// shared types, constants and fixed-point helpers for the color model converter
// no dependencies
package cmr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ARG_W     = 24;
	localparam int FX_W      = FRAC_BITS + 1;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int ALPHA_W   = 17;
	localparam int ALPHA_RSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int ALPHA_LSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int QUANT_W   = FX_W + 10;

	typedef logic [FX_W-1:0] fx_t;

	typedef enum logic [1:0] {
		MODEL_RGB  = 2'd0,
		MODEL_GRAY = 2'd1,
		MODEL_HSV  = 2'd2,
		MODEL_CMYK = 2'd3
	} model_t;

	typedef enum logic [1:0] {
		KIND_DIRECT = 2'd0,
		KIND_HSV    = 2'd1,
		KIND_CMYK   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// hsv: x0 = f, x1 = s, x2 = v; cmyk: x0..x2 = 1 - c/m/y, x3 = 1 - k
	typedef struct packed {
		kind_t              kind;
		logic [2:0]         sector;
		fx_t                x0;
		fx_t                x1;
		fx_t                x2;
		fx_t                x3;
		logic [ALPHA_W-1:0] alpha;
	} cmr_item_t;

	function automatic fx_t fx_clip(input logic signed [ARG_W-1:0] a);
		logic signed [31:0] e;
		e = 32'(a);
		if (e < 0)
			return '0;
		else if (e > ONE)
			return FX_W'(ONE);
		else
			return FX_W'(e);
	endfunction

	function automatic fx_t fx_mul(input fx_t a, input fx_t b);
		logic [2*FX_W-1:0] p;
		p = a * b;
		return FX_W'(p >> FRAC_BITS);
	endfunction

	function automatic logic [ALPHA_W-1:0] to_alpha(input fx_t x);
		logic [63:0] w;
		w = 64'(x);
		w = (w << ALPHA_LSH) >> ALPHA_RSH;
		return ALPHA_W'(w);
	endfunction

	// floor(x*255 + 0.5) with x in [0, one]
	function automatic logic [7:0] quant8(input fx_t x);
		logic [QUANT_W-1:0] t;
		logic [QUANT_W-1:0] q;
		t = QUANT_W'(x) * QUANT_W'(510) + QUANT_W'(ONE);
		q = t >> (FRAC_BITS + 1);
		return (q > QUANT_W'(255)) ? 8'hff : q[7:0];
	endfunction

endpackage

// File: rtl/core/cmr_front.sv
// front end: classifies a directive, applies argument defaults and clipping
// depends on cmr_pkg
module cmr_front (
	input  logic [1:0]                       color_model,
	input  logic [2:0]                       num_args,
	input  logic [4:0]                       numeric_mask,
	input  logic signed [cmr_pkg::ARG_W-1:0] arg0,
	input  logic signed [cmr_pkg::ARG_W-1:0] arg1,
	input  logic signed [cmr_pkg::ARG_W-1:0] arg2,
	input  logic signed [cmr_pkg::ARG_W-1:0] arg3,
	input  logic signed [cmr_pkg::ARG_W-1:0] arg4,
	output cmr_pkg::cmr_item_t               item
);

	logic                             has1, has2, has3, has4, has5;
	logic [cmr_pkg::FRAC_BITS-1:0]    hue;
	logic [cmr_pkg::FRAC_BITS+2:0]    hue6;
	cmr_pkg::fx_t                     one_fx;

	assign one_fx = cmr_pkg::FX_W'(cmr_pkg::ONE);

	// counts of six and seven act as five, so plain compares suffice
	assign has1 = (num_args >= 3'd1);
	assign has2 = (num_args >= 3'd2);
	assign has3 = (num_args >= 3'd3);
	assign has4 = (num_args >= 3'd4);
	assign has5 = (num_args >= 3'd5);

	// fractional part of h, floor semantics, then h*6 splits into sector and f
	assign hue  = (has1 && numeric_mask[0]) ? arg0[cmr_pkg::FRAC_BITS-1:0] : '0;
	assign hue6 = {3'b000, hue} * (cmr_pkg::FRAC_BITS+3)'(6);

	always_comb begin
		item        = '0;
		item.kind   = cmr_pkg::KIND_NONE;
		item.alpha  = cmr_pkg::to_alpha(one_fx);
		unique case (cmr_pkg::model_t'(color_model))
			cmr_pkg::MODEL_RGB: begin
				if (has3 && (numeric_mask[2:0] == 3'b111)) begin
					item.kind = cmr_pkg::KIND_DIRECT;
					item.x0   = cmr_pkg::fx_clip(arg0);
					item.x1   = cmr_pkg::fx_clip(arg1);
					item.x2   = cmr_pkg::fx_clip(arg2);
					if (has4 && numeric_mask[3])
						item.alpha = cmr_pkg::to_alpha(cmr_pkg::fx_clip(arg3));
				end
			end
			cmr_pkg::MODEL_GRAY: begin
				if (has1 && numeric_mask[0]) begin
					item.kind = cmr_pkg::KIND_DIRECT;
					item.x0   = cmr_pkg::fx_clip(arg0);
					item.x1   = cmr_pkg::fx_clip(arg0);
					item.x2   = cmr_pkg::fx_clip(arg0);
					if (has2 && numeric_mask[1])
						item.alpha = cmr_pkg::to_alpha(cmr_pkg::fx_clip(arg1));
				end
			end
			cmr_pkg::MODEL_HSV: begin
				item.kind   = cmr_pkg::KIND_HSV;
				item.sector = hue6[cmr_pkg::FRAC_BITS+2:cmr_pkg::FRAC_BITS];
				item.x0     = cmr_pkg::FX_W'(hue6[cmr_pkg::FRAC_BITS-1:0]);
				item.x1     = (has3 && numeric_mask[1]) ? cmr_pkg::fx_clip(arg1) : one_fx;
				item.x2     = (has3 && numeric_mask[2]) ? cmr_pkg::fx_clip(arg2) : one_fx;
				if (has4 && numeric_mask[3])
					item.alpha = cmr_pkg::to_alpha(cmr_pkg::fx_clip(arg3));
			end
			cmr_pkg::MODEL_CMYK: begin
				item.kind = cmr_pkg::KIND_CMYK;
				item.x0   = one_fx - ((has3 && numeric_mask[0]) ? cmr_pkg::fx_clip(arg0) : '0);
				item.x1   = one_fx - ((has3 && numeric_mask[1]) ? cmr_pkg::fx_clip(arg1) : '0);
				item.x2   = one_fx - ((has3 && numeric_mask[2]) ? cmr_pkg::fx_clip(arg2) : '0);
				item.x3   = one_fx - ((has4 && numeric_mask[3]) ? cmr_pkg::fx_clip(arg3) : '0);
				if (has5 && numeric_mask[4])
					item.alpha = cmr_pkg::to_alpha(cmr_pkg::fx_clip(arg4));
			end
			default: item.kind = cmr_pkg::KIND_NONE;
		endcase
	end

endmodule

// File: rtl/core/cmr_queue.sv
// short queue between the front end and the arithmetic back end
// depends on cmr_pkg
module cmr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cmr_pkg::cmr_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output cmr_pkg::cmr_item_t pop_item
);

	cmr_pkg::cmr_item_t              entry_q [cmr_pkg::QDEPTH];
	logic [cmr_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [cmr_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [cmr_pkg::QCNT_W-1:0]      count_q;

	assign full      = (count_q == cmr_pkg::QCNT_W'(cmr_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];

	function automatic logic [cmr_pkg::QPTR_W-1:0] next_ptr(input logic [cmr_pkg::QPTR_W-1:0] p);
		return (p == cmr_pkg::QPTR_W'(cmr_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/core/cmr_back.sv
// back end: three-stage pipeline that multiplies for hsv and cmyk, then quantizes in the output stage
// depends on cmr_pkg
module cmr_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_avail,
	input  cmr_pkg::cmr_item_t                  item,
	output logic                                item_take,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                valid_res,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	output logic [cmr_pkg::ALPHA_W-1:0]         alpha
);

	logic en1, en2, en3;

	// stage 1 regs
	logic                           vld_s1;
	cmr_pkg::kind_t                 kind_s1;
	logic [2:0]                     sector_s1;
	cmr_pkg::fx_t                   prod0_s1, prod1_s1, prod2_s1;
	cmr_pkg::fx_t                   pass0_s1, pass1_s1, pass2_s1;
	logic [cmr_pkg::ALPHA_W-1:0]    alpha_s1;

	// stage 2 regs
	logic                           vld_s2;
	logic                           ok_s2;
	cmr_pkg::fx_t                   r_s2, g_s2, b_s2;
	logic [cmr_pkg::ALPHA_W-1:0]    alpha_s2;

	// output stage regs
	logic                           vld_s3;

	cmr_pkg::fx_t one_fx;
	cmr_pkg::fx_t ma0, mb0, ma1, mb1, ma2, mb2;
	cmr_pkg::fx_t hq, ht;
	cmr_pkg::fx_t r_nx, g_nx, b_nx;

	assign one_fx    = cmr_pkg::FX_W'(cmr_pkg::ONE);
	assign en3       = !vld_s3 || !out_stall;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign item_take = item_avail && en1;
	assign out_valid = vld_s3;

	// three shared multipliers: hsv takes f*s, (1-f)*s, v*(1-s); cmyk the channels
	always_comb begin
		if (item.kind == cmr_pkg::KIND_HSV) begin
			ma0 = item.x0;          mb0 = item.x1;
			ma1 = one_fx - item.x0; mb1 = item.x1;
			ma2 = item.x2;          mb2 = one_fx - item.x1;
		end else begin
			ma0 = item.x0; mb0 = item.x3;
			ma1 = item.x1; mb1 = item.x3;
			ma2 = item.x2; mb2 = item.x3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1   <= item.kind;
			sector_s1 <= item.sector;
			prod0_s1  <= cmr_pkg::fx_mul(ma0, mb0);
			prod1_s1  <= cmr_pkg::fx_mul(ma1, mb1);
			prod2_s1  <= cmr_pkg::fx_mul(ma2, mb2);
			pass0_s1  <= item.x0;
			pass1_s1  <= item.x1;
			pass2_s1  <= item.x2;
			alpha_s1  <= item.alpha;
		end
	end

	// q = v*(1 - f*s), t = v*(1 - (1-f)*s); s of zero falls out as gray at v
	assign hq = cmr_pkg::fx_mul(pass2_s1, one_fx - prod0_s1);
	assign ht = cmr_pkg::fx_mul(pass2_s1, one_fx - prod1_s1);

	always_comb begin
		r_nx = pass0_s1;
		g_nx = pass1_s1;
		b_nx = pass2_s1;
		case (kind_s1)
			cmr_pkg::KIND_HSV: begin
				case (sector_s1)
					3'd0:    begin r_nx = pass2_s1; g_nx = ht;       b_nx = prod2_s1; end
					3'd1:    begin r_nx = hq;       g_nx = pass2_s1; b_nx = prod2_s1; end
					3'd2:    begin r_nx = prod2_s1; g_nx = pass2_s1; b_nx = ht;       end
					3'd3:    begin r_nx = prod2_s1; g_nx = hq;       b_nx = pass2_s1; end
					3'd4:    begin r_nx = ht;       g_nx = prod2_s1; b_nx = pass2_s1; end
					default: begin r_nx = pass2_s1; g_nx = prod2_s1; b_nx = hq;       end
				endcase
			end
			cmr_pkg::KIND_CMYK: begin
				r_nx = prod0_s1;
				g_nx = prod1_s1;
				b_nx = prod2_s1;
			end
			default: begin
				r_nx = pass0_s1;
				g_nx = pass1_s1;
				b_nx = pass2_s1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			ok_s2    <= (kind_s1 != cmr_pkg::KIND_NONE);
			r_s2     <= r_nx;
			g_s2     <= g_nx;
			b_s2     <= b_nx;
			alpha_s2 <= alpha_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			valid_res <= ok_s2;
			red       <= ok_s2 ? cmr_pkg::quant8(r_s2) : 8'h00;
			green     <= ok_s2 ? cmr_pkg::quant8(g_s2) : 8'h00;
			blue      <= ok_s2 ? cmr_pkg::quant8(b_s2) : 8'h00;
			alpha     <= ok_s2 ? alpha_s2 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1)
				vld_s1 <= item_take;
			if (en2)
				vld_s2 <= vld_s1;
			if (en3)
				vld_s3 <= vld_s2;
		end
	end

endmodule

// File: rtl/core/color_model_to_rgba8.sv
// color_model_to_rgba8: one directive in, one rgba result out, one beat per cycle while nothing stalls
// path: a taken beat is written into the queue, then registered in stage 1, stage 2 and the output stage
// throughput: one beat per cycle unless out_stall holds the stages; at most three 17x17 multiplies per stage
// a two-entry queue and the three back stages absorb output stalls before in_stall rises
// reset: arst_n clears the queue count and pointers and the pipeline valid bits; payload regs are not reset
// depends on cmr_pkg, cmr_front, cmr_queue, cmr_back
module color_model_to_rgba8 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          color_model,
	input  logic [2:0]                          num_args,
	input  logic [4:0]                          numeric_mask,
	input  logic signed [cmr_pkg::ARG_W-1:0]    arg0,
	input  logic signed [cmr_pkg::ARG_W-1:0]    arg1,
	input  logic signed [cmr_pkg::ARG_W-1:0]    arg2,
	input  logic signed [cmr_pkg::ARG_W-1:0]    arg3,
	input  logic signed [cmr_pkg::ARG_W-1:0]    arg4,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                valid_res,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	output logic [cmr_pkg::ALPHA_W-1:0]         alpha
);

	cmr_pkg::cmr_item_t front_item;
	cmr_pkg::cmr_item_t queue_item;
	logic               q_full;
	logic               q_avail;
	logic               q_pop;

	assign in_stall = q_full;

	cmr_front u_front (
		.color_model  (color_model),
		.num_args     (num_args),
		.numeric_mask (numeric_mask),
		.arg0         (arg0),
		.arg1         (arg1),
		.arg2         (arg2),
		.arg3         (arg3),
		.arg4         (arg4),
		.item         (front_item)
	);

	cmr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_avail),
		.pop_item  (queue_item)
	);

	cmr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_avail (q_avail),
		.item       (queue_item),
		.item_take  (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.valid_res  (valid_res),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha)
	);

endmodule

// File: rtl/core/cmr_checker.sv
// port-level checks for color_model_to_rgba8, attached by bind
// depends on assert_macros.svh and cmr_pkg
`include "assert_macros.svh"

module cmr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          valid_res,
	input logic [7:0]                    red,
	input logic [7:0]                    green,
	input logic [7:0]                    blue,
	input logic [cmr_pkg::ALPHA_W-1:0]   alpha
);

	// a stalled output beat stays offered
	`CMR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output beat dropped while stalled")

	// an unresolved directive gives all-zero channels and alpha
	`CMR_ASSERT(a_invalid_zero, !(out_valid && !valid_res) || (red == 8'h00 && green == 8'h00 && blue == 8'h00 && alpha == '0), "unresolved beat has nonzero fields")

	// alpha never exceeds one
	`CMR_ASSERT(a_alpha_range, !out_valid || alpha <= cmr_pkg::ALPHA_W'(65536), "alpha above one")

	// the queue only fills when the back end was blocked by an output stall
	`CMR_ASSERT(a_stall_cause, !$rose(in_stall) || $past(out_valid && out_stall), "input stall without output backpressure")

endmodule

bind color_model_to_rgba8 cmr_checker u_cmr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.valid_res (valid_res),
	.red       (red),
	.green     (green),
	.blue      (blue),
	.alpha     (alpha)
);

// File: sim/rgba8_checker.sv
// checker for color_model_to_rgba8: watches both channels, predicts every rgba result
// in its own fixed-point arithmetic and compares each accepted output beat in order
// depends on cmr_pkg for the model codes and the fraction width
`timescale 1ns / 1ps

module rgba8_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [1:0]                       color_model,
	input  logic [2:0]                       num_args,
	input  logic [4:0]                       numeric_mask,
	input  logic signed [cmr_pkg::ARG_W-1:0] arg0,
	input  logic signed [cmr_pkg::ARG_W-1:0] arg1,
	input  logic signed [cmr_pkg::ARG_W-1:0] arg2,
	input  logic signed [cmr_pkg::ARG_W-1:0] arg3,
	input  logic signed [cmr_pkg::ARG_W-1:0] arg4,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             valid_res,
	input  logic [7:0]                       red,
	input  logic [7:0]                       green,
	input  logic [7:0]                       blue,
	input  logic [cmr_pkg::ALPHA_W-1:0]      alpha,
	output int                               mismatch_cnt,
	output int                               pending_cnt,
	output int                               result_cnt,
	output int                               resolved_cnt
);

	localparam int     FB     = cmr_pkg::FRAC_BITS;
	localparam longint ONE_FX = longint'(1) << FB;

	typedef struct packed {
		logic                        vld;
		logic [7:0]                  r;
		logic [7:0]                  g;
		logic [7:0]                  b;
		logic [cmr_pkg::ALPHA_W-1:0] a;
	} rgba_t;

	rgba_t expected_q[$];
	int    miss = 0;

	function automatic longint unit_clamp(input longint v);
		return (v < 0) ? 0 : ((v > ONE_FX) ? ONE_FX : v);
	endfunction

	// operands are never negative here, so a plain shift is the floor
	function automatic longint fx_product(input longint x, input longint y);
		return (x * y) >> FB;
	endfunction

	function automatic logic [7:0] to_byte(input longint x);
		longint q;
		q = (unit_clamp(x) * 510 + ONE_FX) >> (FB + 1);
		return (q > 255) ? 8'hff : 8'(q);
	endfunction

	function automatic rgba_t predict_rgba(input logic [1:0] model_bits, input logic [2:0] cnt,
			input logic [4:0] mask, input logic signed [cmr_pkg::ARG_W-1:0] a0,
			input logic signed [cmr_pkg::ARG_W-1:0] a1,
			input logic signed [cmr_pkg::ARG_W-1:0] a2,
			input logic signed [cmr_pkg::ARG_W-1:0] a3,
			input logic signed [cmr_pkg::ARG_W-1:0] a4);
		longint arg [5];
		longint rr, gg, bb, aa, h, s, v, h6, f, p, q, t, w, c, m, y, k, u;
		int     n;
		int     sector;
		logic   resolved;
		rgba_t  res;
		arg[0] = a0;
		arg[1] = a1;
		arg[2] = a2;
		arg[3] = a3;
		arg[4] = a4;
		n = (cnt > 5) ? 5 : int'(cnt);
		rr = 0;
		gg = 0;
		bb = 0;
		aa = ONE_FX;
		resolved = 1'b1;
		case (cmr_pkg::model_t'(model_bits))
			cmr_pkg::MODEL_RGB: begin
				if (n < 3 || mask[2:0] != 3'b111) begin
					resolved = 1'b0;
				end else begin
					rr = arg[0];
					gg = arg[1];
					bb = arg[2];
					if (n >= 4 && mask[3]) aa = arg[3];
				end
			end
			cmr_pkg::MODEL_GRAY: begin
				if (n < 1 || !mask[0]) begin
					resolved = 1'b0;
				end else begin
					rr = arg[0];
					gg = arg[0];
					bb = arg[0];
					if (n >= 2 && mask[1]) aa = arg[1];
				end
			end
			cmr_pkg::MODEL_HSV: begin
				h = 0;
				s = ONE_FX;
				v = ONE_FX;
				if (n >= 1 && mask[0]) h = arg[0];
				if (n >= 3) begin
					if (mask[1]) s = arg[1];
					if (mask[2]) v = arg[2];
				end
				if (n >= 4 && mask[3]) aa = arg[3];
				// floor wrap of the hue into one turn
				h = h & (ONE_FX - 1);
				s = unit_clamp(s);
				v = unit_clamp(v);
				if (s == 0) begin
					rr = v;
					gg = v;
					bb = v;
				end else begin
					h6 = h * 6;
					sector = int'(h6 >> FB);
					f = h6 & (ONE_FX - 1);
					p = fx_product(v, ONE_FX - s);
					q = fx_product(v, ONE_FX - fx_product(f, s));
					t = fx_product(v, ONE_FX - fx_product(ONE_FX - f, s));
					case (sector)
						0: begin rr = v; gg = t; bb = p; end
						1: begin rr = q; gg = v; bb = p; end
						2: begin rr = p; gg = v; bb = t; end
						3: begin rr = p; gg = q; bb = v; end
						4: begin rr = t; gg = p; bb = v; end
						default: begin rr = v; gg = p; bb = q; end
					endcase
				end
			end
			default: begin
				c = 0;
				m = 0;
				y = 0;
				k = 0;
				if (n >= 3) begin
					if (mask[0]) c = arg[0];
					if (mask[1]) m = arg[1];
					if (mask[2]) y = arg[2];
				end
				if (n >= 4 && mask[3]) k = arg[3];
				if (n >= 5 && mask[4]) aa = arg[4];
				w = ONE_FX - unit_clamp(k);
				rr = fx_product(ONE_FX - unit_clamp(c), w);
				gg = fx_product(ONE_FX - unit_clamp(m), w);
				bb = fx_product(ONE_FX - unit_clamp(y), w);
			end
		endcase
		res = '0;
		if (resolved) begin
			res.vld = 1'b1;
			res.r = to_byte(rr);
			res.g = to_byte(gg);
			res.b = to_byte(bb);
			u = unit_clamp(aa);
			if (FB >= 16)
				res.a = cmr_pkg::ALPHA_W'(u >> (FB - 16));
			else
				res.a = cmr_pkg::ALPHA_W'(u << (16 - FB));
		end
		return res;
	endfunction

	always @(posedge clk) begin
		rgba_t want;
		rgba_t got;
		if (!arst_n) begin
			mismatch_cnt <= 0;
			pending_cnt  <= 0;
			result_cnt   <= 0;
			resolved_cnt <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_q.push_back(predict_rgba(color_model, num_args, numeric_mask,
					arg0, arg1, arg2, arg3, arg4));
			if (out_valid && !out_stall) begin
				got = '{valid_res, red, green, blue, alpha};
				if (expected_q.size() == 0) begin
					miss++;
					if (miss <= 10)
						$display("%0t: output beat with no directive outstanding: vld=%0d rgb=%0d,%0d,%0d a=%0d",
							$time, valid_res, red, green, blue, alpha);
				end else begin
					want = expected_q.pop_front();
					result_cnt <= result_cnt + 1;
					if (want.vld) resolved_cnt <= resolved_cnt + 1;
					if (got.vld !== want.vld || got.r !== want.r || got.g !== want.g ||
							got.b !== want.b || got.a !== want.a) begin
						miss++;
						if (miss <= 10)
							$display("%0t: mismatch exp vld=%0d rgb=%0d,%0d,%0d a=%0d got vld=%0d rgb=%0d,%0d,%0d a=%0d",
								$time, want.vld, want.r, want.g, want.b, want.a,
								got.vld, got.r, got.g, got.b, got.a);
					end
				end
			end
			mismatch_cnt <= miss;
			pending_cnt  <= expected_q.size();
		end
	end

endmodule

// File: sim/color_model_to_rgba8_tb.sv
// testbench top for color_model_to_rgba8: clock, reset, directive stimulus in bursts,
// output back-pressure and the verdict; checking is done by rgba8_checker
// depends on cmr_pkg, rgba8_checker and the block itself
`timescale 1ns / 1ps

module color_model_to_rgba8_tb;

	localparam int ONEV       = cmr_pkg::ONE;
	localparam int ARG_MAX    = 8388607;
	localparam int ARG_MIN    = -8388608;
	localparam int RAND_BEATS = 1128;
	localparam int IDLE_LIMIT = 4000;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [1:0]                      color_model;
	logic [2:0]                      num_args;
	logic [4:0]                      numeric_mask;
	logic signed [cmr_pkg::ARG_W-1:0] arg0, arg1, arg2, arg3, arg4;
	logic                            out_valid;
	logic                            out_stall;
	logic                            valid_res;
	logic [7:0]                      red, green, blue;
	logic [cmr_pkg::ALPHA_W-1:0]     alpha;

	int mismatch_cnt, pending_cnt, result_cnt, resolved_cnt;
	int sent_cnt    = 0;
	int burst_left  = 0;
	int hold_cnt    = 0;
	int drain_cnt   = 0;
	int idle_cycles = 0;

	always #10 clk = ~clk;

	color_model_to_rgba8 DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.color_model(color_model), .num_args(num_args), .numeric_mask(numeric_mask),
		.arg0(arg0), .arg1(arg1), .arg2(arg2), .arg3(arg3), .arg4(arg4),
		.out_valid(out_valid), .out_stall(out_stall),
		.valid_res(valid_res), .red(red), .green(green), .blue(blue), .alpha(alpha)
	);

	rgba8_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.color_model(color_model), .num_args(num_args), .numeric_mask(numeric_mask),
		.arg0(arg0), .arg1(arg1), .arg2(arg2), .arg3(arg3), .arg4(arg4),
		.out_valid(out_valid), .out_stall(out_stall),
		.valid_res(valid_res), .red(red), .green(green), .blue(blue), .alpha(alpha),
		.mismatch_cnt(mismatch_cnt), .pending_cnt(pending_cnt),
		.result_cnt(result_cnt), .resolved_cnt(resolved_cnt)
	);

	// one directive beat; a new burst may start with a random gap with valid low
	task automatic send_directive(input cmr_pkg::model_t mdl, input logic [2:0] cnt,
			input logic [4:0] mask, input int v0, input int v1, input int v2,
			input int v3, input int v4);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		color_model  <= mdl;
		num_args     <= cnt;
		numeric_mask <= mask;
		arg0 <= cmr_pkg::ARG_W'(v0);
		arg1 <= cmr_pkg::ARG_W'(v1);
		arg2 <= cmr_pkg::ARG_W'(v2);
		arg3 <= cmr_pkg::ARG_W'(v3);
		arg4 <= cmr_pkg::ARG_W'(v4);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_cnt++;
	endtask

	// sender stops until every outstanding result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_cnt != 0);
		drain_cnt++;
	endtask

	function automatic int pick_arg();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return $urandom_range(0, ONEV);
		else if (sel < 8)
			return int'($urandom_range(0, 3 * ONEV / 2)) - ONEV / 4;
		else if (sel == 8)
			return int'($urandom_range(0, 16777215)) - 8388608;
		case ($urandom_range(0, 5))
			0: return 0;
			1: return ONEV;
			2: return ONEV - 1;
			3: return ARG_MAX;
			4: return ARG_MIN;
			default: return -1;
		endcase
	endfunction

	initial begin
		cmr_pkg::model_t mdl;
		logic [2:0]      cnt;
		logic [4:0]      mask;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		color_model  <= '0;
		num_args     <= '0;
		numeric_mask <= '0;
		arg0 <= '0;
		arg1 <= '0;
		arg2 <= '0;
		arg3 <= '0;
		arg4 <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// rgb: plain, out of range with alpha, too short, non-numeric channel, non-numeric alpha
		send_directive(cmr_pkg::MODEL_RGB, 3, 5'h1f, 0, ONEV, ONEV / 2, 0, 0);
		send_directive(cmr_pkg::MODEL_RGB, 4, 5'h1f, -1, ARG_MAX, ARG_MIN, ONEV / 2, 0);
		send_directive(cmr_pkg::MODEL_RGB, 2, 5'h1f, ONEV, ONEV, ONEV, ONEV, ONEV);
		send_directive(cmr_pkg::MODEL_RGB, 3, 5'h05, ONEV / 3, ONEV / 3, ONEV / 3, 0, 0);
		send_directive(cmr_pkg::MODEL_RGB, 4, 5'h07, ONEV / 5, ONEV / 7, ONEV - 1, 0, 0);
		// gray: no argument, non-numeric level, negative alpha, level above one
		send_directive(cmr_pkg::MODEL_GRAY, 0, 5'h1f, ONEV / 2, 0, 0, 0, 0);
		send_directive(cmr_pkg::MODEL_GRAY, 1, 5'h1e, ONEV / 2, 0, 0, 0, 0);
		send_directive(cmr_pkg::MODEL_GRAY, 2, 5'h1f, ONEV / 2, -ONEV / 4, 0, 0, 0);
		send_directive(cmr_pkg::MODEL_GRAY, 1, 5'h01, 2 * ONEV, 0, 0, 0, 0);
		// hue: defaults, negative wrap, s and v ignored below three args, gray at s=0
		send_directive(cmr_pkg::MODEL_HSV, 0, 5'h00, 0, 0, 0, 0, 0);
		send_directive(cmr_pkg::MODEL_HSV, 1, 5'h01, -ONEV / 4, 0, 0, 0, 0);
		send_directive(cmr_pkg::MODEL_HSV, 2, 5'h1f, ONEV / 3, 0, 0, 0, 0);
		send_directive(cmr_pkg::MODEL_HSV, 3, 5'h1f, ONEV / 2, 0, ONEV / 2, 0, 0);
		send_directive(cmr_pkg::MODEL_HSV, 4, 5'h1f, 5 * ONEV / 6 + 100, ONEV / 2, ONEV,
			ONEV / 3, 0);
		send_directive(cmr_pkg::MODEL_HSV, 7, 5'h15, 3 * ONEV + 7, 2 * ONEV, -ONEV, ONEV, 0);
		// cmyk: defaults, c/m ignored below three args, k, alpha, out of range
		send_directive(cmr_pkg::MODEL_CMYK, 0, 5'h00, 0, 0, 0, 0, 0);
		send_directive(cmr_pkg::MODEL_CMYK, 2, 5'h1f, ONEV, ONEV, 0, 0, 0);
		send_directive(cmr_pkg::MODEL_CMYK, 4, 5'h1f, ONEV / 4, ONEV / 2, 0, ONEV / 2, 0);
		send_directive(cmr_pkg::MODEL_CMYK, 5, 5'h1f, 0, ONEV, ONEV / 3, 0, ONEV / 8);
		send_directive(cmr_pkg::MODEL_CMYK, 6, 5'h1f, -ONEV, 2 * ONEV, ONEV / 2, -1, 3 * ONEV);
		// all arguments at the extremes
		send_directive(cmr_pkg::MODEL_RGB, 5, 5'h1f, ARG_MAX, ARG_MAX, ARG_MAX, ARG_MAX,
			ARG_MAX);
		send_directive(cmr_pkg::MODEL_RGB, 5, 5'h1f, ARG_MIN, ARG_MIN, ARG_MIN, ARG_MIN,
			ARG_MIN);
		send_directive(cmr_pkg::MODEL_HSV, 5, 5'h1f, ARG_MIN, ARG_MAX, ARG_MAX, ARG_MIN,
			ARG_MAX);
		drain_results();

		for (int i = 0; i < RAND_BEATS; i++) begin
			if (i == RAND_BEATS / 2) drain_results();
			mdl = cmr_pkg::model_t'($urandom_range(0, 3));
			if ($urandom_range(0, 3) != 0)
				cnt = (mdl == cmr_pkg::MODEL_GRAY) ? 3'($urandom_range(1, 5))
					: 3'($urandom_range(3, 5));
			else
				cnt = 3'($urandom_range(0, 7));
			mask = ($urandom_range(0, 9) < 7) ? 5'h1f : 5'($urandom());
			send_directive(mdl, cnt, mask, pick_arg(), pick_arg(), pick_arg(), pick_arg(),
				pick_arg());
		end
		drain_results();
		repeat (8) @(posedge clk);

		$display("summary: %0d directives sent, %0d results checked, %0d resolved, %0d rejected",
			sent_cnt, result_cnt, resolved_cnt, result_cnt - resolved_cnt);
		$display("summary: %0d long output hold-offs, %0d full drains of the pipeline",
			hold_cnt, drain_cnt);
		if (mismatch_cnt == 0 && pending_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// receiver back-pressure in segments; every sixth segment is a long hold-off
	initial begin
		int seg_mode;
		int seg_len;
		int seg_idx;
		out_stall <= 1'b0;
		seg_idx = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			seg_mode = (seg_idx % 6 == 2) ? 4 : $urandom_range(0, 9);
			seg_len  = $urandom_range(10, 80);
			if (seg_mode == 4) begin
				hold_cnt++;
				seg_len = $urandom_range(40, 60);
			end
			for (int c = 0; c < seg_len; c++) begin
				case (seg_mode)
					0, 1:    out_stall <= 1'b0;
					2, 3:    out_stall <= ($urandom_range(0, 3) == 0);
					5, 6:    out_stall <= ($urandom_range(0, 3) != 0);
					7:       out_stall <= c[0];
					4:       out_stall <= 1'b1;
					default: out_stall <= ($urandom_range(0, 1) == 0);
				endcase
				@(posedge clk);
			end
			seg_idx++;
		end
	end

	// watchdog on cycles in which neither channel moves a beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule
